>>> hw/rtl/rcrb_pkg.sv
package rcrb_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 12;
  localparam int FRAC_W     = 17;
  localparam int GAIN_W     = 16;
  localparam int CH_W       = 8;
  localparam int PROD_W     = DIM_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CROP_FRAC     = 3'd2,
    REG_MID_COL       = 3'd3,
    REG_MID_ROW       = 3'd4,
    REG_QUARTER_TURNS = 3'd5,
    REG_GAIN          = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [FRAC_W-1:0] RST_CROP_FRAC    = 17'd65536;
  localparam logic [FRAC_W-1:0] RST_CENTER       = 17'd32768;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 16'd256;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [FRAC_W-1:0] crop_frac;
    logic [FRAC_W-1:0] mid_col;
    logic [FRAC_W-1:0] mid_row;
    logic [1:0]        quarter_turns;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [CNT_W-1:0] dest_x;
    logic [CNT_W-1:0] dest_y;
    logic             last;
  } pix_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

  // Window span along one axis, as first and last index inside the frame.
  typedef struct packed {
    logic [CNT_W-1:0] first;
    logic [CNT_W-1:0] final_idx;
  } win_axis_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Rounds the Q14.16 products, clamps the size to 1..dim and slides the
  // window so that it stays inside the frame.
  function automatic win_axis_t place_axis(logic [DIM_W-1:0] dim,
                                           logic [PROD_W-1:0] p_size,
                                           logic [PROD_W-1:0] p_cent);
    logic [PROD_W:0]        rs;
    logic [PROD_W:0]        rc;
    logic [PROD_W-16:0]     s;
    logic [PROD_W-16:0]     cen;
    logic [DIM_W-1:0]       sz;
    logic [DIM_W-1:0]       hi;
    logic signed [PROD_W-14:0] st;
    logic [CNT_W-1:0]       left;
    logic [DIM_W-1:0]       end_sum;
    win_axis_t              w;
    rs  = {1'b0, p_size} + (PROD_W+1)'(32768);
    rc  = {1'b0, p_cent} + (PROD_W+1)'(32768);
    s   = rs[PROD_W:16];
    cen = rc[PROD_W:16];
    if (s == '0) begin
      sz = DIM_W'(1);
    end else if (s > (PROD_W-15)'(dim)) begin
      sz = dim;
    end else begin
      sz = s[DIM_W-1:0];
    end
    hi = dim - sz;
    st = $signed((PROD_W-13)'(cen)) - $signed((PROD_W-13)'(sz[DIM_W-1:1]));
    if (st < 0) begin
      left = '0;
    end else if (st > $signed((PROD_W-13)'(hi))) begin
      left = hi[CNT_W-1:0];
    end else begin
      left = st[CNT_W-1:0];
    end
    end_sum     = {1'b0, left} + sz - DIM_W'(1);
    w.first     = left;
    w.final_idx = end_sum[CNT_W-1:0];
    return w;
  endfunction

endpackage

>>> hw/rtl/rcrb_front.sv
module rcrb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  rcrb_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3*rcrb_pkg::CH_W-1:0]       in_pixel,
  input  logic                              in_start,
  input  rcrb_pkg::fifo_stat_t              fifo_stat,
  output logic                              push,
  output rcrb_pkg::pix_entry_t              push_data
);

  logic [rcrb_pkg::DIM_W-1:0]  w;
  logic [rcrb_pkg::DIM_W-1:0]  h;
  logic [rcrb_pkg::CNT_W-1:0]  col_count;
  logic [rcrb_pkg::CNT_W-1:0]  row_count;
  logic [rcrb_pkg::CNT_W-1:0]  pos_col;
  logic [rcrb_pkg::CNT_W-1:0]  pos_row;
  logic [rcrb_pkg::DIM_W-1:0]  col_inc;
  logic [rcrb_pkg::DIM_W-1:0]  row_inc;
  logic [rcrb_pkg::CNT_W-1:0]  col_count_next;
  logic [rcrb_pkg::CNT_W-1:0]  row_count_next;
  logic                        adv;
  logic                        accept;

  logic                             s1_valid;
  logic                             s1_start;
  logic [rcrb_pkg::CNT_W-1:0]       s1_col;
  logic [rcrb_pkg::CNT_W-1:0]       s1_row;
  logic [3*rcrb_pkg::CH_W-1:0]      s1_pixel;
  logic [rcrb_pkg::DIM_W-1:0]       s1_w;
  logic [rcrb_pkg::DIM_W-1:0]       s1_h;
  logic [rcrb_pkg::PROD_W-1:0]      s1_p_wr;
  logic [rcrb_pkg::PROD_W-1:0]      s1_p_wc;
  logic [rcrb_pkg::PROD_W-1:0]      s1_p_hr;
  logic [rcrb_pkg::PROD_W-1:0]      s1_p_hc;

  logic                             s2_valid;
  logic [rcrb_pkg::CNT_W-1:0]       s2_col;
  logic [rcrb_pkg::CNT_W-1:0]       s2_row;
  logic [3*rcrb_pkg::CH_W-1:0]      s2_pixel;

  rcrb_pkg::win_axis_t win_x;
  rcrb_pkg::win_axis_t win_y;
  rcrb_pkg::win_axis_t win_x_next;
  rcrb_pkg::win_axis_t win_y_next;

  logic                        hit;
  logic [rcrb_pkg::CNT_W-1:0]  off_c;
  logic [rcrb_pkg::CNT_W-1:0]  off_r;
  logic [rcrb_pkg::CNT_W-1:0]  flip_c;
  logic [rcrb_pkg::CNT_W-1:0]  flip_r;

  assign w = rcrb_pkg::clamp_dim(cfg.frame_width);
  assign h = rcrb_pkg::clamp_dim(cfg.frame_height);

  // The whole front moves in lockstep; it only holds when a window pixel
  // cannot go into the queue.
  assign adv      = !(s2_valid && hit && fifo_stat.full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_comb begin
    pos_col = in_start ? '0 : col_count;
    pos_row = in_start ? '0 : row_count;
    col_inc = {1'b0, pos_col} + rcrb_pkg::DIM_W'(1);
    row_inc = {1'b0, pos_row} + rcrb_pkg::DIM_W'(1);
    if (col_inc >= w) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h) ? '0 : row_inc[rcrb_pkg::CNT_W-1:0];
    end else begin
      col_count_next = col_inc[rcrb_pkg::CNT_W-1:0];
      row_count_next = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_start <= in_start;
      s1_col   <= pos_col;
      s1_row   <= pos_row;
      s1_pixel <= in_pixel;
      s1_w     <= w;
      s1_h     <= h;
      s1_p_wr  <= w * cfg.crop_frac;
      s1_p_wc  <= w * cfg.mid_col;
      s1_p_hr  <= h * cfg.crop_frac;
      s1_p_hc  <= h * cfg.mid_row;
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_pixel <= s1_pixel;
    end
  end

  assign win_x_next = rcrb_pkg::place_axis(s1_w, s1_p_wr, s1_p_wc);
  assign win_y_next = rcrb_pkg::place_axis(s1_h, s1_p_hr, s1_p_hc);

  // After reset the window is the single pixel at the origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_x <= '0;
      win_y <= '0;
    end else if (adv && s1_valid && s1_start) begin
      win_x <= win_x_next;
      win_y <= win_y_next;
    end
  end

  always_comb begin
    hit    = (s2_col >= win_x.first) && (s2_col <= win_x.final_idx) &&
             (s2_row >= win_y.first) && (s2_row <= win_y.final_idx);
    off_c  = s2_col - win_x.first;
    off_r  = s2_row - win_y.first;
    flip_c = win_x.final_idx - s2_col;
    flip_r = win_y.final_idx - s2_row;
    push_data.blue  = s2_pixel[rcrb_pkg::CH_W-1:0];
    push_data.green = s2_pixel[2*rcrb_pkg::CH_W-1:rcrb_pkg::CH_W];
    push_data.red   = s2_pixel[3*rcrb_pkg::CH_W-1:2*rcrb_pkg::CH_W];
    push_data.last  = (s2_col == win_x.final_idx) && (s2_row == win_y.final_idx);
    case (rcrb_pkg::rot_e'(cfg.quarter_turns))
      rcrb_pkg::ROT_0: begin
        push_data.dest_x = off_c;
        push_data.dest_y = off_r;
      end
      rcrb_pkg::ROT_90: begin
        push_data.dest_x = off_r;
        push_data.dest_y = flip_c;
      end
      rcrb_pkg::ROT_180: begin
        push_data.dest_x = flip_c;
        push_data.dest_y = flip_r;
      end
      default: begin
        push_data.dest_x = flip_r;
        push_data.dest_y = off_c;
      end
    endcase
  end

  assign push = s2_valid && hit && !fifo_stat.full;

endmodule

>>> hw/rtl/rcrb_fifo.sv
module rcrb_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rcrb_pkg::pix_entry_t  push_data,
  input  logic                  pop,
  output rcrb_pkg::pix_entry_t  head,
  output rcrb_pkg::fifo_stat_t  stat
);

  rcrb_pkg::pix_entry_t              mem [rcrb_pkg::FIFO_DEPTH];
  logic [rcrb_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [rcrb_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [rcrb_pkg::FIFO_CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rcrb_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rcrb_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rcrb_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rcrb_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == rcrb_pkg::FIFO_CNT_W'(rcrb_pkg::FIFO_DEPTH));
  assign stat.valid = (count != '0);

endmodule

>>> hw/rtl/rcrb_back.sv
module rcrb_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rcrb_pkg::GAIN_W-1:0]  gain,
  input  rcrb_pkg::pix_entry_t         head,
  input  rcrb_pkg::fifo_stat_t         fifo_stat,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [47:0]                  out_data,
  output logic                         out_last
);

  localparam int PW = rcrb_pkg::CH_W + rcrb_pkg::GAIN_W;
  localparam logic [rcrb_pkg::CH_W-1:0] SAT_MAX = 8'd255;

  logic                        b1_valid;
  logic [PW-1:0]               b1_blue;
  logic [PW-1:0]               b1_green;
  logic [PW-1:0]               b1_red;
  logic [rcrb_pkg::CNT_W-1:0]  b1_dest_x;
  logic [rcrb_pkg::CNT_W-1:0]  b1_dest_y;
  logic                        b1_last;
  logic                        out_adv;
  logic                        b1_adv;

  // Rounds away the fraction of the Q16.8 product and saturates at full scale.
  function automatic logic [rcrb_pkg::CH_W-1:0] round_sat(logic [PW-1:0] p);
    logic [PW:0] t;
    logic [rcrb_pkg::CH_W-1:0] r;
    t = {1'b0, p} + (PW+1)'(128);
    if (t[PW:8] > (PW-7)'(SAT_MAX)) begin
      r = SAT_MAX;
    end else begin
      r = t[15:8];
    end
    return r;
  endfunction

  assign out_adv = !out_valid || out_ready;
  assign b1_adv  = !b1_valid || out_adv;
  assign pop     = fifo_stat.valid && b1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b1_adv) begin
        b1_valid <= fifo_stat.valid;
      end
      if (out_adv) begin
        out_valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) begin
      b1_blue   <= head.blue * gain;
      b1_green  <= head.green * gain;
      b1_red    <= head.red * gain;
      b1_dest_x <= head.dest_x;
      b1_dest_y <= head.dest_y;
      b1_last   <= head.last;
    end
    if (out_adv) begin
      out_data <= {b1_dest_y, b1_dest_x, round_sat(b1_red), round_sat(b1_green),
                   round_sat(b1_blue)};
      out_last <= b1_last;
    end
  end

endmodule

>>> hw/rtl/roi_crop_rotate_brighten.sv
// Data path: a pixel inside the crop window passes the front registers s1 and s2,
// the queue, the back register b1 and the output register on its way out.
// Throughput: one pixel per cycle while neither side stalls; pixels outside the
// window give no output. A four-entry queue lets the two sides stall on their own.
// Reset: synchronous; clears counters, queue and handshakes, loads the register
// defaults and sets the crop window to the single pixel at the origin.
module roi_crop_rotate_brighten (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,  // blue_in, green_in, red_in
  input  logic                               s_axis_tuser,  // frame_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // blue_out, green_out, red_out, dest_x, dest_y
  output logic [47:0]                        m_axis_tdata,
  output logic                               m_axis_tlast,  // last_pixel
  input  logic                               cfg_write,
  input  logic [rcrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcrb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rcrb_pkg::cfg_t        cfg;
  rcrb_pkg::fifo_stat_t  fifo_stat;
  rcrb_pkg::pix_entry_t  push_data;
  rcrb_pkg::pix_entry_t  head;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= rcrb_pkg::RST_FRAME_WIDTH;
      cfg.frame_height  <= rcrb_pkg::RST_FRAME_HEIGHT;
      cfg.crop_frac     <= rcrb_pkg::RST_CROP_FRAC;
      cfg.mid_col       <= rcrb_pkg::RST_CENTER;
      cfg.mid_row       <= rcrb_pkg::RST_CENTER;
      cfg.quarter_turns <= rcrb_pkg::ROT_0;
      cfg.gain          <= rcrb_pkg::RST_GAIN;
    end else if (cfg_write) begin
      case (rcrb_pkg::cfg_reg_e'(cfg_index))
        rcrb_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[rcrb_pkg::DIM_W-1:0];
        rcrb_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[rcrb_pkg::DIM_W-1:0];
        rcrb_pkg::REG_CROP_FRAC:     cfg.crop_frac     <= cfg_data;
        rcrb_pkg::REG_MID_COL:       cfg.mid_col       <= cfg_data;
        rcrb_pkg::REG_MID_ROW:       cfg.mid_row       <= cfg_data;
        rcrb_pkg::REG_QUARTER_TURNS: cfg.quarter_turns <= cfg_data[1:0];
        rcrb_pkg::REG_GAIN:          cfg.gain          <= cfg_data[rcrb_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pixel  (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  rcrb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  rcrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gain      (cfg.gain),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // The input side only stalls because the queue is full.
  a_ready_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> fifo_stat.full)
    else $error("input stalled while the queue had room");

  // A full queue stays full until the back end drains an entry.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.full && !pop |=> fifo_stat.full)
    else $error("queue lost an entry without a pop");

  // Nothing is presented on the output right after reset.
  a_out_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

>>> tb/tb.sv
module tb;
  import rcrb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PIPE_SETTLE  = 8;
  localparam int RANDOM_UNTIL = 920;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic        last_px;
  } pix_out_t;

  typedef enum {STEP_PIXEL, STEP_WRITE} step_kind_e;
  typedef enum {OUT_MODEL, OUT_GIVEN, OUT_NONE} out_mode_e;

  typedef struct {
    step_kind_e  kind;
    cfg_reg_e    idx;
    logic [16:0] value;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic        fs;
    out_mode_e   mode;
    pix_out_t    given;
  } step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_valid;
  logic        s_ready;
  logic [23:0] s_data;
  logic        s_frame_start;
  logic        m_valid;
  logic        m_ready;
  logic [47:0] m_data;
  logic        m_last;
  logic        cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  roi_crop_rotate_brighten dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),        // blue_in, green_in, red_in
    .s_axis_tuser  (s_frame_start), // frame_start
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),        // blue_out, green_out, red_out, dest_x, dest_y
    .m_axis_tlast  (m_last),        // last_pixel
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Register shadow and window state of the crop predictor.
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  logic [16:0] reg_ratio;
  logic [16:0] reg_cx;
  logic [16:0] reg_cy;
  rot_e        reg_turns;
  logic [15:0] reg_gain;
  int col_pos, row_pos, win_left, win_top, win_cols, win_rows;

  pix_out_t pending_pixels[$];
  int pixels_sent;
  int pixels_checked = 0;
  int frames_started;
  int mismatches = 0;
  int cycles = 0;
  logic calm;

  // One quiet stretch in the middle of the run with no idling on either side.
  assign calm = (pixels_sent >= 400) && (pixels_sent < 600);

  always begin
    #4 clk = ~clk;
  end

  function automatic int fit_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void place_span(input int dim, input longint ratio, input longint centre,
                                     output int start, output int size);
    longint s;
    longint c;
    longint st;
    s = (longint'(dim) * ratio + 32768) >>> 16;
    c = (longint'(dim) * centre + 32768) >>> 16;
    if (s < 1) s = 1;
    if (s > dim) s = dim;
    st = c - s / 2;
    if (st < 0) st = 0;
    if (st > dim - s) st = dim - s;
    start = int'(st);
    size  = int'(s);
  endfunction

  function automatic logic [7:0] brighten(input logic [7:0] v);
    int p;
    p = (int'(v) * int'(reg_gain) + 128) >>> 8;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [16:0] v);
    case (idx)
      REG_FRAME_WIDTH:   reg_width  = v[12:0];
      REG_FRAME_HEIGHT:  reg_height = v[12:0];
      REG_CROP_FRAC:     reg_ratio  = v;
      REG_MID_COL:       reg_cx     = v;
      REG_MID_ROW:       reg_cy     = v;
      REG_QUARTER_TURNS: reg_turns  = rot_e'(v[1:0]);
      REG_GAIN:          reg_gain   = v[15:0];
      default: ;
    endcase
  endfunction

  // Advances the position counters by one pixel and tells whether the pixel
  // falls inside the crop window, with its expected output.
  function automatic bit crop_pixel(input logic [7:0] b, g, r, input logic fs,
                                    output pix_out_t res);
    int w, h, c, rr, dx, dy;
    bit hit;
    w = fit_dim(reg_width);
    h = fit_dim(reg_height);
    if (fs) begin
      place_span(w, reg_ratio, reg_cx, win_left, win_cols);
      place_span(h, reg_ratio, reg_cy, win_top, win_rows);
      col_pos = 0;
      row_pos = 0;
    end
    hit = col_pos >= win_left && col_pos < win_left + win_cols &&
          row_pos >= win_top && row_pos < win_top + win_rows;
    res = '0;
    if (hit) begin
      c  = col_pos - win_left;
      rr = row_pos - win_top;
      case (reg_turns)
        ROT_0: begin
          dx = c;
          dy = rr;
        end
        ROT_90: begin
          dx = rr;
          dy = win_cols - 1 - c;
        end
        ROT_180: begin
          dx = win_cols - 1 - c;
          dy = win_rows - 1 - rr;
        end
        default: begin
          dx = win_rows - 1 - rr;
          dy = c;
        end
      endcase
      res.blue    = brighten(b);
      res.green   = brighten(g);
      res.red     = brighten(r);
      res.dest_x  = dx[11:0];
      res.dest_y  = dy[11:0];
      res.last_px = (c == win_cols - 1) && (rr == win_rows - 1);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return hit;
  endfunction

  function automatic step_t px(input logic [7:0] b, g, r, input logic fs,
                               input out_mode_e mode = OUT_MODEL,
                               input pix_out_t given = '0);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.idx   = REG_FRAME_WIDTH;
    s.value = '0;
    s.b     = b;
    s.g     = g;
    s.r     = r;
    s.fs    = fs;
    s.mode  = mode;
    s.given = given;
    return s;
  endfunction

  function automatic step_t wr(input cfg_reg_e idx, input logic [16:0] value);
    step_t s;
    s       = px(8'd0, 8'd0, 8'd0, 1'b0);
    s.kind  = STEP_WRITE;
    s.idx   = idx;
    s.value = value;
    return s;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(6))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] b, g, r, input logic fs,
                            input out_mode_e mode, input pix_out_t given);
    pix_out_t res;
    bit hit;
    while (!calm && $urandom_range(99) < 10) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid       <= 1'b1;
    s_data        <= {r, g, b};
    s_frame_start <= fs;
    do @(posedge clk); while (!s_ready);
    hit = crop_pixel(b, g, r, fs, res);
    pixels_sent++;
    if (fs) frames_started++;
    case (mode)
      OUT_MODEL: if (hit) pending_pixels.push_back(res);
      OUT_GIVEN: pending_pixels.push_back(given);
      default: ;
    endcase
  endtask

  // Holds the sender until every expected pixel has come out, then lets the
  // pipeline empty of pixels that fall outside the window.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [16:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    apply_reg(idx, v);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [16:0] pick_dim(input int small_max);
    case ($urandom_range(19))
      0:       return 17'd0;
      1:       return 17'd4096;
      2:       return 17'h1FFF;
      3:       return 17'($urandom_range(8191));
      default: return 17'($urandom_range(1, small_max));
    endcase
  endfunction

  function automatic logic [16:0] pick_ratio();
    case ($urandom_range(5))
      0:       return 17'd65536;
      1:       return 17'($urandom_range(1, 65536));
      2:       return 17'($urandom_range(17'h1FFFF));
      3:       return 17'($urandom_range(16384, 49152));
      4:       return 17'($urandom_range(1));
      default: return 17'd32768;
    endcase
  endfunction

  function automatic logic [16:0] pick_centre();
    case ($urandom_range(4))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(17'h1FFFF));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [16:0] pick_gain();
    case ($urandom_range(5))
      0:       return 17'd0;
      1:       return 17'd65535;
      2, 3:    return 17'd256;
      4:       return 17'($urandom_range(1023));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  // Output side: random stalls, checked against the oldest expected pixel.
  always @(posedge clk) begin
    m_ready <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    pix_out_t exp_px;
    if (!rst && m_valid && m_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("output pixel with nothing expected: tdata=%h tlast=%b", m_data, m_last);
        mismatches++;
      end else begin
        exp_px = pending_pixels.pop_front();
        pixels_checked++;
        if (m_data[7:0] !== exp_px.blue) begin
          $error("blue_out: expected %0d, got %0d", exp_px.blue, m_data[7:0]);
          mismatches++;
        end
        if (m_data[15:8] !== exp_px.green) begin
          $error("green_out: expected %0d, got %0d", exp_px.green, m_data[15:8]);
          mismatches++;
        end
        if (m_data[23:16] !== exp_px.red) begin
          $error("red_out: expected %0d, got %0d", exp_px.red, m_data[23:16]);
          mismatches++;
        end
        if (m_data[35:24] !== exp_px.dest_x) begin
          $error("dest_x: expected %0d, got %0d", exp_px.dest_x, m_data[35:24]);
          mismatches++;
        end
        if (m_data[47:36] !== exp_px.dest_y) begin
          $error("dest_y: expected %0d, got %0d", exp_px.dest_y, m_data[47:36]);
          mismatches++;
        end
        if (m_last !== exp_px.last_px) begin
          $error("last_pixel: expected %0d, got %0d", exp_px.last_px, m_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycles,
               pending_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    step_t script[$];
    bit busy;
    int phases;
    int frames;
    int npix;
    int full;
    int lost;
    logic fs;

    rst            = 1'b1;
    s_valid        = 1'b0;
    s_data         = '0;
    s_frame_start  = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pixels_sent    = 0;
    frames_started = 0;
    busy           = 1'b0;
    phases         = 0;
    lost           = 0;

    reg_width  = RST_FRAME_WIDTH;
    reg_height = RST_FRAME_HEIGHT;
    reg_ratio  = RST_CROP_FRAC;
    reg_cx     = RST_CENTER;
    reg_cy     = RST_CENTER;
    reg_turns  = ROT_0;
    reg_gain   = RST_GAIN;
    col_pos    = 0;
    row_pos    = 0;
    win_left   = 0;
    win_top    = 0;
    win_cols   = 1;
    win_rows   = 1;

    // Reset window is the origin pixel alone, so the first pixel is also the last.
    script.push_back(px(8'h00, 8'h00, 8'h00, 1'b0, OUT_GIVEN,
                        '{8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1}));
    script.push_back(px(8'hFF, 8'hFF, 8'hFF, 1'b0, OUT_NONE));
    // Full 1920x1080 frame at unity gain passes pixels straight through.
    script.push_back(px(8'h12, 8'h34, 8'h56, 1'b1, OUT_GIVEN,
                        '{8'h12, 8'h34, 8'h56, 12'd0, 12'd0, 1'b0}));
    script.push_back(px(8'hFF, 8'h80, 8'h01, 1'b0, OUT_GIVEN,
                        '{8'hFF, 8'h80, 8'h01, 12'd1, 12'd0, 1'b0}));
    // 3x2 frame, quarter turn, zero gain; the seventh pixel wraps into a new frame.
    script.push_back(wr(REG_FRAME_WIDTH, 17'd3));
    script.push_back(wr(REG_FRAME_HEIGHT, 17'd2));
    script.push_back(wr(REG_QUARTER_TURNS, 17'(ROT_90)));
    script.push_back(wr(REG_GAIN, 17'd0));
    script.push_back(px(8'hAA, 8'h55, 8'hFF, 1'b1, OUT_GIVEN,
                        '{8'h00, 8'h00, 8'h00, 12'd0, 12'd2, 1'b0}));
    for (int i = 0; i < 6; i++) script.push_back(px(rand_chan(), rand_chan(), rand_chan(), 1'b0));
    // Minimum ratio with the centre at the far right edge: a single pixel at
    // column 2, saturated by the largest gain.
    script.push_back(wr(REG_GAIN, 17'd65535));
    script.push_back(wr(REG_QUARTER_TURNS, 17'(ROT_180)));
    script.push_back(wr(REG_CROP_FRAC, 17'd1));
    script.push_back(wr(REG_MID_COL, 17'd65536));
    script.push_back(wr(REG_MID_ROW, 17'd0));
    script.push_back(px(8'h01, 8'h00, 8'h80, 1'b1, OUT_NONE));
    script.push_back(px(8'h01, 8'h00, 8'h80, 1'b0, OUT_NONE));
    script.push_back(px(8'h01, 8'h02, 8'hFF, 1'b0, OUT_GIVEN,
                        '{8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0, 1'b1}));
    script.push_back(px(8'h00, 8'h00, 8'h00, 1'b0));
    // Out-of-range width and height, ratio and centre beyond one.
    script.push_back(wr(REG_FRAME_WIDTH, 17'h1FFF));
    script.push_back(wr(REG_FRAME_HEIGHT, 17'd0));
    script.push_back(wr(REG_CROP_FRAC, 17'h1FFFF));
    script.push_back(wr(REG_MID_COL, 17'd0));
    script.push_back(wr(REG_MID_ROW, 17'h1FFFF));
    script.push_back(wr(REG_QUARTER_TURNS, 17'(ROT_270)));
    script.push_back(wr(REG_GAIN, 17'd128));
    script.push_back(px(8'hFF, 8'h00, 8'h81, 1'b1));
    for (int i = 0; i < 4; i++) script.push_back(px(rand_chan(), rand_chan(), rand_chan(), 1'b0));
    // Rotation changed in the middle of a frame takes effect at once.
    script.push_back(wr(REG_QUARTER_TURNS, 17'(ROT_90)));
    for (int i = 0; i < 3; i++) script.push_back(px(rand_chan(), rand_chan(), rand_chan(), 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        if (busy) begin
          wait_idle();
          busy = 1'b0;
        end
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_pixel(script[i].b, script[i].g, script[i].r, script[i].fs,
                   script[i].mode, script[i].given);
        busy = 1'b1;
      end
    end

    while (pixels_sent < RANDOM_UNTIL) begin
      wait_idle();
      phases++;
      if ($urandom_range(1)) write_reg(REG_FRAME_WIDTH, pick_dim(12));
      if ($urandom_range(1)) write_reg(REG_FRAME_HEIGHT, pick_dim(8));
      if ($urandom_range(1)) write_reg(REG_CROP_FRAC, pick_ratio());
      if ($urandom_range(1)) write_reg(REG_MID_COL, pick_centre());
      if ($urandom_range(1)) write_reg(REG_MID_ROW, pick_centre());
      if ($urandom_range(1)) write_reg(REG_QUARTER_TURNS, 17'($urandom_range(3)));
      if ($urandom_range(1)) write_reg(REG_GAIN, pick_gain());
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        full = fit_dim(reg_width) * fit_dim(reg_height);
        if (full > 150) begin
          npix = $urandom_range(20, 80);
        end else if ($urandom_range(99) < 15) begin
          // Short or overlong frame.
          npix = $urandom_range(1, full + fit_dim(reg_width) + 2);
        end else begin
          npix = full;
        end
        for (int p = 0; p < npix; p++) begin
          if (p == 0) begin
            fs = !(f == 0 && $urandom_range(9) == 0);
          end else begin
            fs = ($urandom_range(99) < 2);
          end
          send_pixel(rand_chan(), rand_chan(), rand_chan(), fs, OUT_MODEL, '0);
        end
      end
    end

    s_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending_pixels.size() != 0; i++) @(posedge clk);
    repeat (16) @(posedge clk);
    lost = pending_pixels.size();
    if (lost != 0) begin
      $error("%0d expected pixels never came out", lost);
    end

    $display("Streamed %0d pixels in %0d frame starts over %0d register settings,",
             pixels_sent, frames_started, phases + 5);
    $display("checked %0d cropped, rotated and brightened pixels; %0d mismatches.",
             pixels_checked, mismatches);
    if (mismatches == 0 && lost == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
